/* hdl/imuf_pkg.sv */
`timescale 1ns / 1ps

package imuf_pkg;

  // frame layout
  localparam int FRAME_LEN   = 11;
  localparam int STORE_DEPTH = 10;
  localparam int READ_DEPTH  = 7;
  localparam int CNT_W       = 4;
  localparam int IDX_W       = $clog2(STORE_DEPTH);

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_RATE  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  // frame kind codes on the result
  localparam logic KIND_RATE  = 1'b0;
  localparam logic KIND_ANGLE = 1'b1;

  // raw/32768*full_scale*128 == raw*full_scale/256
  localparam int ANGLE_PROD_W = 25;
  localparam int RATE_PROD_W  = 28;
  localparam logic signed [ANGLE_PROD_W-1:0] ANGLE_MUL = 25'sd180;
  localparam logic signed [RATE_PROD_W-1:0]  RATE_MUL  = 28'sd2000;
  localparam logic signed [ANGLE_PROD_W-1:0] ANGLE_BIAS = 25'sd255;
  localparam logic signed [RATE_PROD_W-1:0]  RATE_BIAS  = 28'sd255;

  localparam int ANGLE_W = 16;
  localparam int RATE_W  = 19;

  typedef struct packed {
    logic        emit;
    logic        kind;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
    logic [15:0] raw_z;
  } frame_evt_t;

  typedef struct packed {
    logic                      kind;
    logic signed [ANGLE_W-1:0] x_angle;
    logic signed [ANGLE_W-1:0] y_angle;
    logic signed [ANGLE_W-1:0] z_angle;
    logic signed [RATE_W-1:0]  z_rate;
  } result_t;

endpackage

/* hdl/imuf_frame_track.sv */
`timescale 1ns / 1ps

module imuf_frame_track (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [7:0]           rx_byte,
  output imuf_pkg::frame_evt_t evt
);

  logic [imuf_pkg::CNT_W-1:0] byte_count;
  logic                       in_frame;
  logic [7:0]                 frame_bytes [imuf_pkg::STORE_DEPTH];

  logic [imuf_pkg::CNT_W-1:0] count_inc;
  logic [imuf_pkg::CNT_W-1:0] wr_idx;
  logic                       is_hdr;
  logic                       store_wr;
  logic                       done;
  logic [7:0]                 rd [imuf_pkg::READ_DEPTH];

  assign is_hdr    = (rx_byte == imuf_pkg::HDR_BYTE);
  assign count_inc = byte_count + imuf_pkg::CNT_W'(1);
  assign wr_idx    = byte_count - imuf_pkg::CNT_W'(1);
  assign store_wr  = !is_hdr && in_frame && (byte_count != '0) &&
                     (wr_idx < imuf_pkg::CNT_W'(imuf_pkg::STORE_DEPTH));
  assign done      = !is_hdr && in_frame &&
                     (count_inc == imuf_pkg::CNT_W'(imuf_pkg::FRAME_LEN));

  // a byte being stored is forwarded to its read position in the same cycle it is written
  always_comb begin
    for (int k = 0; k < imuf_pkg::READ_DEPTH; k++) begin
      rd[k] = (store_wr && wr_idx == imuf_pkg::CNT_W'(k)) ? rx_byte : frame_bytes[k];
    end
  end

  always_comb begin
    evt.emit  = done && (rd[0] == imuf_pkg::TYPE_RATE || rd[0] == imuf_pkg::TYPE_ANGLE);
    evt.kind  = (rd[0] == imuf_pkg::TYPE_ANGLE) ? imuf_pkg::KIND_ANGLE : imuf_pkg::KIND_RATE;
    evt.raw_x = {rd[2], rd[1]};
    evt.raw_y = {rd[4], rd[3]};
    evt.raw_z = {rd[6], rd[5]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      in_frame   <= 1'b0;
    end else if (fire) begin
      if (is_hdr) begin
        in_frame   <= 1'b1;
        byte_count <= imuf_pkg::CNT_W'(1);
      end else if (in_frame) begin
        if (done) begin
          in_frame   <= 1'b0;
          byte_count <= '0;
        end else begin
          byte_count <= count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && store_wr) begin
      frame_bytes[wr_idx[imuf_pkg::IDX_W-1:0]] <= rx_byte;
    end
  end

  a_count_tracks_frame: assert property (@(posedge clk) disable iff (rst)
    in_frame == (byte_count != '0))
    else $error("byte count and frame flag disagree");

  a_emit_in_frame: assert property (@(posedge clk) disable iff (rst)
    evt.emit |-> in_frame)
    else $error("result raised outside a frame");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count < imuf_pkg::CNT_W'(imuf_pkg::FRAME_LEN))
    else $error("byte count ran past frame length");

endmodule

/* hdl/imuf_scale.sv */
`timescale 1ns / 1ps

module imuf_scale (
  input  imuf_pkg::frame_evt_t evt,
  output imuf_pkg::result_t    res
);

  // truncation toward zero: bias negative products before the shift
  function automatic logic signed [imuf_pkg::ANGLE_W-1:0] angle_of(logic [15:0] raw);
    logic signed [imuf_pkg::ANGLE_PROD_W-1:0] p;
    logic signed [imuf_pkg::ANGLE_PROD_W-1:0] q;
    p = $signed({{(imuf_pkg::ANGLE_PROD_W-16){raw[15]}}, raw}) * imuf_pkg::ANGLE_MUL;
    q = p[imuf_pkg::ANGLE_PROD_W-1] ? p + imuf_pkg::ANGLE_BIAS : p;
    return q[imuf_pkg::ANGLE_W+7:8];
  endfunction

  function automatic logic signed [imuf_pkg::RATE_W-1:0] rate_of(logic [15:0] raw);
    logic signed [imuf_pkg::RATE_PROD_W-1:0] p;
    logic signed [imuf_pkg::RATE_PROD_W-1:0] q;
    p = $signed({{(imuf_pkg::RATE_PROD_W-16){raw[15]}}, raw}) * imuf_pkg::RATE_MUL;
    q = p[imuf_pkg::RATE_PROD_W-1] ? p + imuf_pkg::RATE_BIAS : p;
    return q[imuf_pkg::RATE_W+7:8];
  endfunction

  always_comb begin
    res.kind = evt.kind;
    if (evt.kind == imuf_pkg::KIND_ANGLE) begin
      res.x_angle = angle_of(evt.raw_x);
      res.y_angle = angle_of(evt.raw_y);
      res.z_angle = angle_of(evt.raw_z);
      res.z_rate  = '0;
    end else begin
      res.x_angle = '0;
      res.y_angle = '0;
      res.z_angle = '0;
      res.z_rate  = rate_of(evt.raw_z);
    end
  end

endmodule

/* hdl/imu_frame_parser_unit.sv */
`timescale 1ns / 1ps

// Frame parser for an IMU serial link: takes one received byte per transfer,
// one transfer per cycle unless the input stalls. A 0x55 byte always starts a new frame; the frame
// completes at eleven bytes, and a type byte of 0x52 gives the z rotation rate
// while 0x53 gives the x, y and z angles, all signed with 7 fractional bits.
// Other frames and stray bytes give nothing. A byte passes through the input
// register and then, once it moves on, its result (if any) is captured in the
// result register that drives the result port. The input stalls only when a
// completing frame finds the result register still holding an untaken result.

module imu_frame_parser_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_stall,
  input  logic [7:0]         rx_byte,
  output logic               res_valid,
  input  logic               res_stall,
  output logic               frame_kind,
  output logic signed [15:0] x_angle,
  output logic signed [15:0] y_angle,
  output logic signed [15:0] z_angle,
  output logic signed [18:0] z_rate
);

  logic                 s1_vld;
  logic [7:0]           s1_byte;
  imuf_pkg::frame_evt_t evt;
  imuf_pkg::result_t    res;
  logic                 out_free;
  logic                 s1_fire;

  assign out_free = !res_valid || !res_stall;
  assign s1_fire  = s1_vld && (!evt.emit || out_free);
  assign rx_stall = s1_vld && !s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (!rx_stall) begin
      s1_vld <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rx_stall && rx_valid) begin
      s1_byte <= rx_byte;
    end
  end

  imuf_frame_track u_track (
    .clk     (clk),
    .rst     (rst),
    .fire    (s1_fire),
    .rx_byte (s1_byte),
    .evt     (evt)
  );

  imuf_scale u_scale (
    .evt (evt),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && evt.emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && evt.emit) begin
      frame_kind <= res.kind;
      x_angle    <= res.x_angle;
      y_angle    <= res.y_angle;
      z_angle    <= res.z_angle;
      z_rate     <= res.z_rate;
    end
  end

  a_rise_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(s1_fire && evt.emit))
    else $error("result appeared without a completed frame");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> s1_vld)
    else $error("input stalled with an empty stage");

  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    s1_fire && evt.emit |=> res_valid)
    else $error("completed frame result dropped");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |-> !(s1_fire && evt.emit))
    else $error("pending result overwritten");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 650;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rx_valid = 1'b0;
  logic rx_stall;
  logic [7:0] rx_byte = 8'h00;
  logic res_valid;
  logic res_stall = 1'b0;
  logic frame_kind;
  logic signed [15:0] x_angle;
  logic signed [15:0] y_angle;
  logic signed [15:0] z_angle;
  logic signed [18:0] z_rate;

  imu_frame_parser_unit u_dut (
    .clk(clk),
    .rst(rst),
    .rx_valid(rx_valid),
    .rx_stall(rx_stall),
    .rx_byte(rx_byte),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .frame_kind(frame_kind),
    .x_angle(x_angle),
    .y_angle(y_angle),
    .z_angle(z_angle),
    .z_rate(z_rate)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [7:0] tx_bytes[$];
  imuf_pkg::result_t want_frames[$];
  int queued = 0;
  int mismatches = 0;
  int results_seen = 0;
  int cycles = 0;

  // parser state mirrored on the testbench side
  logic [3:0] frame_pos;
  logic frame_open;
  logic [7:0] frame_store[imuf_pkg::STORE_DEPTH];

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) note_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  function automatic int raw16(input int lo);
    return int'($signed({frame_store[lo + 1], frame_store[lo]}));
  endfunction

  // raw/32768*full_scale in 7 fractional bits, truncated toward zero
  function automatic int deg_fixed(input int raw, input int full_scale);
    return (raw * full_scale) / 256;
  endfunction

  task automatic track_byte(input logic [7:0] b);
    imuf_pkg::result_t r;
    if (b == imuf_pkg::HDR_BYTE) begin
      frame_open = 1'b1;
      frame_pos = 4'd1;
    end else if (frame_open) begin
      if (frame_pos >= 4'd1 && int'(frame_pos) - 1 < imuf_pkg::STORE_DEPTH) begin
        frame_store[frame_pos - 4'd1] = b;
      end
      frame_pos = frame_pos + 4'd1;
      if (int'(frame_pos) == imuf_pkg::FRAME_LEN) begin
        frame_open = 1'b0;
        frame_pos = 4'd0;
        r = '0;
        if (frame_store[0] == imuf_pkg::TYPE_RATE) begin
          r.kind = imuf_pkg::KIND_RATE;
          r.z_rate = 19'(deg_fixed(raw16(5), 2000));
          want_frames.push_back(r);
        end else if (frame_store[0] == imuf_pkg::TYPE_ANGLE) begin
          r.kind = imuf_pkg::KIND_ANGLE;
          r.x_angle = 16'(deg_fixed(raw16(1), 180));
          r.y_angle = 16'(deg_fixed(raw16(3), 180));
          r.z_angle = 16'(deg_fixed(raw16(5), 180));
          want_frames.push_back(r);
        end
      end
    end
  endtask

  // sender: bursts of random length with random gaps
  int gap_left = 0;
  int burst_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
      frame_pos = 4'd0;
      frame_open = 1'b0;
      for (int i = 0; i < imuf_pkg::STORE_DEPTH; i++) frame_store[i] = 8'h00;
      gap_left = 0;
      burst_left = $urandom_range(1, 24);
    end else begin
      if (rx_valid && !rx_stall) begin
        track_byte(rx_byte);
        void'(tx_bytes.pop_front());
      end
      if (rx_valid && rx_stall) begin
        // stalled transfer keeps its payload
      end else if (gap_left > 0) begin
        gap_left--;
        rx_valid <= 1'b0;
      end else if (tx_bytes.size() == 0) begin
        rx_valid <= 1'b0;
      end else begin
        rx_valid <= 1'b1;
        rx_byte <= tx_bytes[0];
        if (burst_left <= 1) begin
          if ($urandom_range(0, 3) == 0) begin
            gap_left = 0;
            burst_left = $urandom_range(20, 60);
          end else begin
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 3);
            burst_left = $urandom_range(1, 24);
          end
        end else begin
          burst_left--;
        end
      end
    end
  end

  // receiver: checks results and stalls on a shifting pattern, with one long hold
  logic [15:0] stall_bits = '0;
  int stall_left = 0;
  int hold_left = 0;
  logic long_hold_done = 1'b0;

  always @(posedge clk) begin
    imuf_pkg::result_t w;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        results_seen++;
        if (want_frames.size() == 0) begin
          note_mismatch("result transfer with nothing expected");
        end else begin
          w = want_frames.pop_front();
          check_field("frame_kind", int'(frame_kind), int'(w.kind));
          check_field("x_angle", int'(x_angle), int'(w.x_angle));
          check_field("y_angle", int'(y_angle), int'(w.y_angle));
          check_field("z_angle", int'(z_angle), int'(w.z_angle));
          check_field("z_rate", int'(z_rate), int'(w.z_rate));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (!long_hold_done && results_seen >= 12) begin
        // long hold so the parser backs up and stalls its input
        long_hold_done = 1'b1;
        hold_left = 400;
        res_stall <= 1'b1;
      end else begin
        if (stall_left == 0) begin
          stall_left = 16;
          case ($urandom_range(0, 3))
            0: stall_bits = '0;
            1: stall_bits = 16'($urandom & $urandom);
            2: stall_bits = 16'($urandom);
            default: stall_bits = 16'($urandom | $urandom);
          endcase
        end
        res_stall <= stall_bits[0];
        stall_bits = stall_bits >> 1;
        stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    queued++;
  endtask

  // frame body byte, a header byte only now and then
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == imuf_pkg::HDR_BYTE && $urandom_range(0, 19) != 0) b = 8'($urandom_range(0, 84));
    return b;
  endfunction

  task automatic queue_frame(input logic [7:0] kind_byte);
    logic [15:0] pair;
    queue_byte(imuf_pkg::HDR_BYTE);
    queue_byte(kind_byte);
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 11))
        0: pair = 16'h8000;
        1: pair = 16'h7fff;
        2: pair = 16'hffff;
        3: pair = 16'h0000;
        default: pair = {body_byte(), body_byte()};
      endcase
      queue_byte(pair[7:0]);
      queue_byte(pair[15:8]);
    end
    for (int i = 0; i < imuf_pkg::FRAME_LEN - 8; i++) queue_byte(body_byte());
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (tx_bytes.size() != 0 || rx_valid || want_frames.size() != 0);
  endtask

  initial begin
    logic [7:0] t;
    int pick;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // stray byte, then an angle frame at the raw extremes
    queue_byte(8'h00);
    queue_byte(imuf_pkg::HDR_BYTE);
    queue_byte(imuf_pkg::TYPE_ANGLE);
    queue_byte(8'h00); queue_byte(8'h80);
    queue_byte(8'hff); queue_byte(8'h7f);
    queue_byte(8'hff); queue_byte(8'hff);
    queue_byte(8'h11); queue_byte(8'h22); queue_byte(8'hff);
    // frame cut short by a new header, then a rate frame at full negative scale
    queue_byte(imuf_pkg::HDR_BYTE);
    queue_byte(imuf_pkg::TYPE_RATE);
    queue_byte(imuf_pkg::HDR_BYTE);
    queue_byte(imuf_pkg::TYPE_RATE);
    queue_byte(8'h01); queue_byte(8'h02); queue_byte(8'h03); queue_byte(8'h04);
    queue_byte(8'h00); queue_byte(8'h80);
    queue_byte(8'h7f); queue_byte(8'hfe); queue_byte(8'h00);
    wait_drained();

    for (int phase = 0; phase < 2; phase++) begin
      while (queued < 25 + (phase + 1) * RANDOM_ITEMS / 2) begin
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
          queue_frame(imuf_pkg::TYPE_ANGLE);
        end else if (pick < 82) begin
          queue_frame(imuf_pkg::TYPE_RATE);
        end else if (pick < 88) begin
          do t = 8'($urandom);
          while (t == imuf_pkg::TYPE_RATE || t == imuf_pkg::TYPE_ANGLE ||
                 t == imuf_pkg::HDR_BYTE);
          queue_frame(t);
        end else if (pick < 94) begin
          // broken frame, finished off by whatever follows
          queue_byte(imuf_pkg::HDR_BYTE);
          queue_byte($urandom_range(0, 1) ? imuf_pkg::TYPE_RATE : imuf_pkg::TYPE_ANGLE);
          repeat ($urandom_range(0, 8)) queue_byte(body_byte());
        end else begin
          repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
        end
      end
      // sender stays quiet until every result is back
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && want_frames.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
